### rtl/twqd_pkg.sv
// Shared constants, codes and types for the two-queue weighted dequeue block.
// No dependencies; imported by the entry store and the top level.
`default_nettype none

package twqd_pkg;

    // Default number of entries held by each queue.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths of an item and of one stored entry.
    localparam int MODE_W   = 2;
    localparam int ID_W     = 32;
    localparam int TICKET_W = 16;
    localparam int STATUS_W = 3;
    localparam int LIMIT_W  = 4;
    localparam int ENTRY_W  = ID_W + TICKET_W;

    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [MODE_W-1:0]   t_mode;

    // Reset value of the preferential burst limit.
    localparam logic [LIMIT_W-1:0] BURST_LIMIT_RST = 4'd2;

    // Operation codes carried in the mode field.
    localparam t_mode MODE_ENQ_NORM = 2'd0;
    localparam t_mode MODE_ENQ_PREF = 2'd1;
    localparam t_mode MODE_DEQ      = 2'd2;
    localparam t_mode MODE_NONE     = 2'd3;

    // Result status codes.
    localparam t_status ST_ENQUEUED  = 3'd0;
    localparam t_status ST_DUPLICATE = 3'd1;
    localparam t_status ST_FULL      = 3'd2;
    localparam t_status ST_DEQUEUED  = 3'd3;
    localparam t_status ST_EMPTY     = 3'd4;

endpackage

`default_nettype wire

### rtl/twqd_store.sv
// Entry store for both queues: one write port and one read port, read data registered.
// Depends on twqd_pkg for the entry width.
`default_nettype none

module twqd_store
    import twqd_pkg::*;
#(
    parameter int ADDR_W = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_wr_en,
    input  wire logic [ADDR_W-1:0]  i_wr_addr,
    input  wire logic [ENTRY_W-1:0] i_wr_data,
    input  wire logic               i_rd_en,
    input  wire logic [ADDR_W-1:0]  i_rd_addr,
    output logic      [ENTRY_W-1:0] o_rd_data
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [ENTRY_W-1:0] r_mem [0:DEPTH-1];
    logic [ENTRY_W-1:0] r_rd_data;

    // Write port. Entries are undefined until an enqueue fills them.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data read appears in the cycle after the read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/two_queue_weighted_dequeue_core.sv
// Top level of the two-queue weighted dequeue block: sequencer, queue pointers and burst count.
// Depends on twqd_pkg and twqd_store, which holds the entries of both queues.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_stall    i_mode, i_item_id, i_ticket
//   out       output     o_out_valid / i_out_stall  o_status, o_from_preferential,
//                                                   o_out_id, o_out_ticket
//   cfg       input      i_cfg_we                   i_cfg_data (pref_burst_limit)
//
// An enqueue first checks the target queue for a duplicate, reading one stored entry per
// cycle through the single read port of the entry store, and stops early when a duplicate
// turns up. A dequeue reads the head entry of the chosen queue and skips that read when
// both queues are empty.
// One item is in work at a time; the finished result sits in an output register, so a
// stall on the output holds only the next result, not the acceptance of the next item.
// Reset (synchronous, active low) empties both queues, clears the burst count and sets
// the burst limit to two; no clearing pass is needed. An item of mode 3 gives no result.
`default_nettype none

module two_queue_weighted_dequeue_core
    import twqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Input items.
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [MODE_W-1:0]          i_mode,
    input  wire logic signed [ID_W-1:0]     i_item_id,
    input  wire logic [TICKET_W-1:0]        i_ticket,
    // Result items.
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [STATUS_W-1:0]             o_status,
    output logic                            o_from_preferential,
    output logic signed [ID_W-1:0]          o_out_id,
    output logic [TICKET_W-1:0]             o_out_ticket,
    // Burst limit register.
    input  wire logic                       i_cfg_we,
    input  wire logic [LIMIT_W-1:0]         i_cfg_data
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int AW = QW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMD  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Slot of a queue entry: head plus offset, wrapped at the queue depth.
    function automatic logic [QW-1:0] slot_of(input logic [QW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[QW-1:0];
    endfunction

    // Control state.
    logic [2:0]          r_state, n_state;
    logic [QW-1:0]       r_norm_head, n_norm_head;
    logic [QW-1:0]       r_pref_head, n_pref_head;
    logic [CW-1:0]       r_norm_count, n_norm_count;
    logic [CW-1:0]       r_pref_count, n_pref_count;
    logic [LIMIT_W-1:0]  r_burst, n_burst;
    logic [LIMIT_W-1:0]  r_limit, n_limit;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic                r_out_valid, n_out_valid;

    // Item and result payload.
    t_mode               r_mode, n_mode;
    logic [ID_W-1:0]     r_id, n_id;
    logic [TICKET_W-1:0] r_ticket, n_ticket;
    t_status             r_res_status, n_res_status;
    logic                r_res_pref, n_res_pref;
    logic [ID_W-1:0]     r_res_id, n_res_id;
    logic [TICKET_W-1:0] r_res_ticket, n_res_ticket;
    t_status             r_out_status, n_out_status;
    logic                r_out_pref, n_out_pref;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic [TICKET_W-1:0] r_out_ticket, n_out_ticket;

    // Store access.
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [ENTRY_W-1:0]  rd_data;

    // Enqueue target queue.
    logic                tgt_pref;
    logic [QW-1:0]       tgt_head;
    logic [CW-1:0]       tgt_count;
    logic [QW-1:0]       scan_slot;
    logic [QW-1:0]       tail_slot;
    logic                scan_hit;
    logic                out_free;

    // Dequeue decision inputs.
    logic                pref_nz;
    logic                norm_nz;
    logic                burst_low;

    twqd_store #(
        .ADDR_W (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_id, r_ticket}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Target queue of an enqueue and the slots it touches.
    assign tgt_pref  = (r_mode == MODE_ENQ_PREF);
    assign tgt_head  = tgt_pref ? r_pref_head : r_norm_head;
    assign tgt_count = tgt_pref ? r_pref_count : r_norm_count;
    assign scan_slot = slot_of(tgt_head, r_idx);
    assign tail_slot = slot_of(tgt_head, tgt_count);
    assign scan_hit  = r_pend && (rd_data[ENTRY_W-1:TICKET_W] == r_id);

    assign pref_nz   = (r_pref_count != '0);
    assign norm_nz   = (r_norm_count != '0);
    assign burst_low = (r_burst < r_limit);

    assign out_free  = !r_out_valid || !i_out_stall;

    // Sequencer and queue bookkeeping.
    always_comb begin
        n_state      = r_state;
        n_norm_head  = r_norm_head;
        n_pref_head  = r_pref_head;
        n_norm_count = r_norm_count;
        n_pref_count = r_pref_count;
        n_burst      = r_burst;
        n_limit      = r_limit;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && i_out_stall;
        n_mode       = r_mode;
        n_id         = r_id;
        n_ticket     = r_ticket;
        n_res_status = r_res_status;
        n_res_pref   = r_res_pref;
        n_res_id     = r_res_id;
        n_res_ticket = r_res_ticket;
        n_out_status = r_out_status;
        n_out_pref   = r_out_pref;
        n_out_id     = r_out_id;
        n_out_ticket = r_out_ticket;
        wr_en        = 1'b0;
        wr_addr      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;

        // The limit is to be written only while the block is idle; the block itself does not enforce this.
        if (i_cfg_we) begin
            n_limit = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = i_mode;
                    n_id     = i_item_id;
                    n_ticket = i_ticket;
                    if (i_mode != MODE_NONE) begin
                        n_state = S_CMD;
                    end
                end
            end

            S_CMD: begin
                n_res_pref   = 1'b0;
                n_res_id     = '0;
                n_res_ticket = '0;
                unique case (r_mode)
                    MODE_ENQ_NORM, MODE_ENQ_PREF: begin
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end
                    MODE_DEQ: begin
                        n_res_status = ST_DEQUEUED;
                        n_state      = S_POP;
                        // Preferential first under limit, then one normal entry; else any nonempty queue.
                        priority if (pref_nz && burst_low) begin
                            rd_en        = 1'b1;
                            rd_addr      = {1'b1, r_pref_head};
                            n_pref_head  = slot_of(r_pref_head, CW'(1));
                            n_pref_count = r_pref_count - CW'(1);
                            n_burst      = r_burst + LIMIT_W'(1);
                            n_res_pref   = 1'b1;
                        end else if (!burst_low && norm_nz) begin
                            rd_en        = 1'b1;
                            rd_addr      = {1'b0, r_norm_head};
                            n_norm_head  = slot_of(r_norm_head, CW'(1));
                            n_norm_count = r_norm_count - CW'(1);
                            n_burst      = '0;
                        end else if (pref_nz) begin
                            rd_en        = 1'b1;
                            rd_addr      = {1'b1, r_pref_head};
                            n_pref_head  = slot_of(r_pref_head, CW'(1));
                            n_pref_count = r_pref_count - CW'(1);
                            n_res_pref   = 1'b1;
                        end else if (norm_nz) begin
                            rd_en        = 1'b1;
                            rd_addr      = {1'b0, r_norm_head};
                            n_norm_head  = slot_of(r_norm_head, CW'(1));
                            n_norm_count = r_norm_count - CW'(1);
                        end else begin
                            n_res_status = ST_EMPTY;
                            n_state      = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_SCAN: begin
                // One read issued per cycle; its compare lands in the next cycle.
                priority if (scan_hit) begin
                    n_pend       = 1'b0;
                    n_res_status = ST_DUPLICATE;
                    n_state      = S_DONE;
                end else if (r_idx != tgt_count) begin
                    rd_en   = 1'b1;
                    rd_addr = {tgt_pref, scan_slot};
                    n_idx   = r_idx + CW'(1);
                    n_pend  = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else if (tgt_count == DEPTH_C) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = {tgt_pref, tail_slot};
                    if (tgt_pref) begin
                        n_pref_count = r_pref_count + CW'(1);
                    end else begin
                        n_norm_count = r_norm_count + CW'(1);
                    end
                    n_res_status = ST_ENQUEUED;
                    n_state      = S_DONE;
                end
            end

            S_POP: begin
                n_res_id     = rd_data[ENTRY_W-1:TICKET_W];
                n_res_ticket = rd_data[TICKET_W-1:0];
                n_state      = S_DONE;
            end

            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_pref   = r_res_pref;
                    n_out_id     = r_res_id;
                    n_out_ticket = r_res_ticket;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_norm_head  <= '0;
            r_pref_head  <= '0;
            r_norm_count <= '0;
            r_pref_count <= '0;
            r_burst      <= '0;
            r_limit      <= BURST_LIMIT_RST;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_norm_head  <= n_norm_head;
            r_pref_head  <= n_pref_head;
            r_norm_count <= n_norm_count;
            r_pref_count <= n_pref_count;
            r_burst      <= n_burst;
            r_limit      <= n_limit;
            r_idx        <= n_idx;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_id         <= n_id;
        r_ticket     <= n_ticket;
        r_res_status <= n_res_status;
        r_res_pref   <= n_res_pref;
        r_res_id     <= n_res_id;
        r_res_ticket <= n_res_ticket;
        r_out_status <= n_out_status;
        r_out_pref   <= n_out_pref;
        r_out_id     <= n_out_id;
        r_out_ticket <= n_out_ticket;
    end

    // Ports.
    assign o_in_stall          = (r_state != S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out_status;
    assign o_from_preferential = r_out_pref;
    assign o_out_id            = r_out_id;
    assign o_out_ticket        = r_out_ticket;

endmodule

`default_nettype wire
